// ----- src/pssd_pkg.sv -----
// ----------------------------------------------------------------------------
// pssd_pkg
// Shared types and constants for the PWM speed scaler with deadband.
// ----------------------------------------------------------------------------
package pssd_pkg;

    // Q2.14 full scale
    localparam logic signed [15:0] ONE_Q     = 16'sd16384;
    localparam logic signed [15:0] NEG_ONE_Q = -16'sd16384;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MAX_PULSE     = 3'd0;
    localparam t_cfg_idx CFG_DEADBAND_HIGH = 3'd1;
    localparam t_cfg_idx CFG_CENTER_PULSE  = 3'd2;
    localparam t_cfg_idx CFG_DEADBAND_LOW  = 3'd3;
    localparam t_cfg_idx CFG_MIN_PULSE     = 3'd4;
    localparam t_cfg_idx CFG_SKIP_DEADBAND = 3'd5;

    // Commands
    localparam logic CMD_FORWARD = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    typedef struct packed {
        logic              command;
        logic signed [15:0] speed_in;
        logic [11:0]       raw_in;
    } t_in_word;

    typedef struct packed {
        logic [11:0]       raw_out;
        logic signed [15:0] speed_out;
        logic              saturated;
    } t_out_word;

    typedef struct packed {
        logic [11:0] max_pulse;
        logic [11:0] deadband_high;
        logic [11:0] center_pulse;
        logic [11:0] deadband_low;
        logic [11:0] min_pulse;
        logic        skip_deadband;
    } t_cfg;

    // Inverse-mode result selection
    typedef enum logic [1:0] {
        INV_ZERO,
        INV_POS_FULL,
        INV_NEG_FULL,
        INV_DIV
    } t_inv_sel;

    typedef struct packed {
        logic     cmd;
        t_inv_sel sel;
        logic     neg;
    } t_ctl;

    // Forward operands after clamp and side selection
    typedef struct packed {
        logic signed [15:0] speed;
        logic signed [13:0] scale;
        logic signed [13:0] off;
    } t_fwd;

    // Restoring divider state: partial remainder, pending numerator bits,
    // quotient so far and divisor
    typedef struct packed {
        logic [11:0] rem;
        logic [14:0] num;
        logic [14:0] quo;
        logic [11:0] dvs;
    } t_div;

endpackage

// ----- src/pssd_cfg.sv -----
// ----------------------------------------------------------------------------
// pssd_cfg
// Configuration register file for the scaler bounds and deadband mode.
// ----------------------------------------------------------------------------
module pssd_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  pssd_pkg::t_cfg_idx i_cfg_index,
    input  logic [11:0]       i_cfg_data,
    output logic              o_cfg_ready,
    output pssd_pkg::t_cfg    o_cfg
);

    pssd_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pssd_pkg::CFG_MAX_PULSE:     r_cfg.max_pulse     <= i_cfg_data;
                pssd_pkg::CFG_DEADBAND_HIGH: r_cfg.deadband_high <= i_cfg_data;
                pssd_pkg::CFG_CENTER_PULSE:  r_cfg.center_pulse  <= i_cfg_data;
                pssd_pkg::CFG_DEADBAND_LOW:  r_cfg.deadband_low  <= i_cfg_data;
                pssd_pkg::CFG_MIN_PULSE:     r_cfg.min_pulse     <= i_cfg_data;
                pssd_pkg::CFG_SKIP_DEADBAND: r_cfg.skip_deadband <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- src/pssd_front.sv -----
// ----------------------------------------------------------------------------
// pssd_front
// Input decode: side bounds and scales, speed clamp, inverse range tests and
// divider setup.
// ----------------------------------------------------------------------------
module pssd_front #(
    parameter int DISABLED_CODE = 0
) (
    input  pssd_pkg::t_in_word i_word,
    input  pssd_pkg::t_cfg     i_cfg,
    output pssd_pkg::t_ctl     o_ctl,
    output pssd_pkg::t_fwd     o_fwd,
    output pssd_pkg::t_div     o_div
);

    localparam logic [11:0] DisCode = 12'(DISABLED_CODE);

    logic signed [13:0] ctr_s;
    logic signed [13:0] max_s;
    logic signed [13:0] min_s;
    logic signed [13:0] raw_s;
    logic signed [13:0] minpos;
    logic signed [13:0] maxneg;
    logic signed [13:0] pscale;
    logic signed [13:0] nscale;
    logic signed [13:0] dpos;
    logic signed [13:0] dneg;
    logic signed [15:0] spd;
    logic [11:0]        dsel;
    logic [11:0]        psel;

    always_comb begin
        ctr_s  = {2'b00, i_cfg.center_pulse};
        max_s  = {2'b00, i_cfg.max_pulse};
        min_s  = {2'b00, i_cfg.min_pulse};
        raw_s  = {2'b00, i_word.raw_in};
        minpos = i_cfg.skip_deadband ? {2'b00, i_cfg.deadband_high} : ctr_s + 14'sd1;
        maxneg = i_cfg.skip_deadband ? {2'b00, i_cfg.deadband_low}  : ctr_s - 14'sd1;
        pscale = max_s - minpos;
        nscale = maxneg - min_s;
        dpos   = raw_s - minpos;
        dneg   = maxneg - raw_s;

        // clamp to plus or minus one
        if (i_word.speed_in > pssd_pkg::ONE_Q) begin
            spd = pssd_pkg::ONE_Q;
        end else if (i_word.speed_in < pssd_pkg::NEG_ONE_Q) begin
            spd = pssd_pkg::NEG_ONE_Q;
        end else begin
            spd = i_word.speed_in;
        end

        o_fwd.speed = spd;
        if (spd == 16'sd0) begin
            o_fwd.scale = 14'sd0;
            o_fwd.off   = ctr_s;
        end else if (!spd[15]) begin
            o_fwd.scale = pscale;
            o_fwd.off   = minpos;
        end else begin
            o_fwd.scale = nscale;
            o_fwd.off   = maxneg;
        end

        o_ctl.cmd = i_word.command;
        o_ctl.neg = 1'b0;
        dsel      = dpos[11:0];
        psel      = pscale[11:0];
        if (i_word.raw_in == DisCode) begin
            o_ctl.sel = pssd_pkg::INV_ZERO;
        end else if (raw_s > max_s) begin
            o_ctl.sel = pssd_pkg::INV_POS_FULL;
        end else if (raw_s < min_s) begin
            o_ctl.sel = pssd_pkg::INV_NEG_FULL;
        end else if (raw_s > minpos) begin
            o_ctl.sel = pssd_pkg::INV_DIV;
        end else if (raw_s < maxneg) begin
            o_ctl.sel = pssd_pkg::INV_DIV;
            o_ctl.neg = 1'b1;
            dsel      = dneg[11:0];
            psel      = nscale[11:0];
        end else begin
            o_ctl.sel = pssd_pkg::INV_ZERO;
        end

        // dividend is dsel << 14; the quotient never exceeds 2^14, so the
        // remainder starts from the bits above quotient bit 14
        o_div.rem = {1'b0, dsel[11:1]};
        o_div.num = {dsel[0], 14'b0};
        o_div.quo = '0;
        o_div.dvs = psel;
    end

endmodule

// ----- src/pssd_div_stage.sv -----
// ----------------------------------------------------------------------------
// pssd_div_stage
// A slice of the restoring divider: STEPS quotient bits per pipeline stage.
// ----------------------------------------------------------------------------
module pssd_div_stage #(
    parameter int STEPS = 4
) (
    input  pssd_pkg::t_div i_div,
    output pssd_pkg::t_div o_div
);

    logic [12:0] trial;
    logic [11:0] rem;
    logic [14:0] num;
    logic [14:0] quo;

    always_comb begin
        rem   = i_div.rem;
        num   = i_div.num;
        quo   = i_div.quo;
        trial = '0;
        for (int k = 0; k < STEPS; k++) begin
            trial = {rem, num[14]};
            num   = {num[13:0], 1'b0};
            if (trial >= {1'b0, i_div.dvs}) begin
                rem = 12'(trial - {1'b0, i_div.dvs});
                quo = {quo[13:0], 1'b1};
            end else begin
                rem = trial[11:0];
                quo = {quo[13:0], 1'b0};
            end
        end
        o_div.rem = rem;
        o_div.num = num;
        o_div.quo = quo;
        o_div.dvs = i_div.dvs;
    end

endmodule

// ----- src/pssd_fwd.sv -----
// ----------------------------------------------------------------------------
// pssd_fwd
// Forward finish: round half up, add side offset, saturate to the code range.
// ----------------------------------------------------------------------------
module pssd_fwd #(
    parameter int CODE_BITS = 12
) (
    input  logic signed [29:0] i_prod,
    input  logic signed [13:0] i_off,
    output logic [11:0]        o_raw,
    output logic               o_sat
);

    localparam logic signed [17:0] CodeMax = 18'((1 << CODE_BITS) - 1);

    logic signed [30:0] rounded;
    logic signed [16:0] scaled;
    logic signed [17:0] code;

    always_comb begin
        rounded = {i_prod[29], i_prod} + 31'sd8192;
        scaled  = rounded[30:14];
        code    = {scaled[16], scaled} + {{4{i_off[13]}}, i_off};
        if (code[17]) begin
            o_raw = '0;
            o_sat = 1'b1;
        end else if (code > CodeMax) begin
            o_raw = CodeMax[11:0];
            o_sat = 1'b1;
        end else begin
            o_raw = code[11:0];
            o_sat = 1'b0;
        end
    end

endmodule

// ----- src/pwm_speed_scaler_deadband_top.sv -----
// ----------------------------------------------------------------------------
// pwm_speed_scaler_deadband_top
// Speed-to-pulse and pulse-to-speed scaler with programmable deadband.
// ----------------------------------------------------------------------------
// Takes one word per cycle while o_stall is low and returns each result in
// order. Five register stages: decode and clamp, then four stages that hold
// the 15 quotient bits of the restoring divider (4, 4, 4 and 3 bits); the
// forward multiply and the rounding/saturation ride alongside in stages two
// and three. The divider depth sets the latency. Each stage moves up when the
// one ahead is empty or moving, so bubbles close up and o_stall rises only
// when every stage holds a word and the output is stalled.
module pwm_speed_scaler_deadband_top #(
    parameter int DISABLED_CODE = 0,
    parameter int CODE_BITS     = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  pssd_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output pssd_pkg::t_out_word o_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  pssd_pkg::t_cfg_idx  i_cfg_index,
    input  logic [11:0]         i_cfg_data
);

    pssd_pkg::t_cfg cfg;
    pssd_pkg::t_ctl front_ctl;
    pssd_pkg::t_fwd front_fwd;
    pssd_pkg::t_div front_div;
    pssd_pkg::t_div div2;
    pssd_pkg::t_div div3;
    pssd_pkg::t_div div4;
    pssd_pkg::t_div div5;
    logic [11:0]    fwd_raw;
    logic           fwd_sat;

    logic en1, en2, en3, en4, en5;

    // stage 1
    logic           r_v1;
    pssd_pkg::t_ctl r_s1_ctl;
    pssd_pkg::t_fwd r_s1_fwd;
    pssd_pkg::t_div r_s1_div;
    // stage 2
    logic               r_v2;
    pssd_pkg::t_ctl     r_s2_ctl;
    logic signed [29:0] r_s2_prod;
    logic signed [13:0] r_s2_off;
    pssd_pkg::t_div     r_s2_div;
    // stage 3
    logic           r_v3;
    pssd_pkg::t_ctl r_s3_ctl;
    logic [11:0]    r_s3_raw;
    logic           r_s3_sat;
    pssd_pkg::t_div r_s3_div;
    // stage 4
    logic           r_v4;
    pssd_pkg::t_ctl r_s4_ctl;
    logic [11:0]    r_s4_raw;
    logic           r_s4_sat;
    pssd_pkg::t_div r_s4_div;
    // stage 5 (output)
    logic                r_v5;
    pssd_pkg::t_out_word r_out;
    pssd_pkg::t_out_word n_out;

    pssd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    pssd_front #(.DISABLED_CODE(DISABLED_CODE)) u_front (
        .i_word (i_word),
        .i_cfg  (cfg),
        .o_ctl  (front_ctl),
        .o_fwd  (front_fwd),
        .o_div  (front_div)
    );

    pssd_div_stage #(.STEPS(4)) u_div2 (.i_div(r_s1_div), .o_div(div2));
    pssd_div_stage #(.STEPS(4)) u_div3 (.i_div(r_s2_div), .o_div(div3));
    pssd_div_stage #(.STEPS(4)) u_div4 (.i_div(r_s3_div), .o_div(div4));
    pssd_div_stage #(.STEPS(3)) u_div5 (.i_div(r_s4_div), .o_div(div5));

    pssd_fwd #(.CODE_BITS(CODE_BITS)) u_fwd (
        .i_prod (r_s2_prod),
        .i_off  (r_s2_off),
        .o_raw  (fwd_raw),
        .o_sat  (fwd_sat)
    );

    // advance a stage when it is empty or the one ahead advances
    assign en5 = !r_v5 || !i_stall;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_stall = !en1;
    assign o_valid = r_v5;
    assign o_word  = r_out;

    always_comb begin
        n_out = '0;
        if (r_s4_ctl.cmd == pssd_pkg::CMD_FORWARD) begin
            n_out.raw_out   = r_s4_raw;
            n_out.saturated = r_s4_sat;
        end else begin
            case (r_s4_ctl.sel)
                pssd_pkg::INV_POS_FULL: n_out.speed_out = pssd_pkg::ONE_Q;
                pssd_pkg::INV_NEG_FULL: n_out.speed_out = pssd_pkg::NEG_ONE_Q;
                pssd_pkg::INV_DIV: begin
                    n_out.speed_out = r_s4_ctl.neg ? -$signed({1'b0, div5.quo})
                                                   :  $signed({1'b0, div5.quo});
                end
                default: n_out.speed_out = '0;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_ctl <= front_ctl;
            r_s1_fwd <= front_fwd;
            r_s1_div <= front_div;
        end
        if (en2) begin
            r_s2_ctl  <= r_s1_ctl;
            r_s2_prod <= 30'(r_s1_fwd.speed) * 30'(r_s1_fwd.scale);
            r_s2_off  <= r_s1_fwd.off;
            r_s2_div  <= div2;
        end
        if (en3) begin
            r_s3_ctl <= r_s2_ctl;
            r_s3_raw <= fwd_raw;
            r_s3_sat <= fwd_sat;
            r_s3_div <= div3;
        end
        if (en4) begin
            r_s4_ctl <= r_s3_ctl;
            r_s4_raw <= r_s3_raw;
            r_s4_sat <= r_s3_sat;
            r_s4_div <= div4;
        end
        if (en5) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- src/pssd_checker.sv -----
// ----------------------------------------------------------------------------
// pssd_checker
// Port-level checks for the PWM speed scaler, bound to the top level.
// ----------------------------------------------------------------------------
module pssd_checker #(
    parameter int CODE_BITS = 12
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input pssd_pkg::t_out_word o_word
);

    localparam logic [11:0] SatHigh = 12'((1 << CODE_BITS) - 1);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("output word changed while stalled");

    // an inverse result never carries forward fields
    a_mode_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.speed_out != 16'sd0 |->
            o_word.raw_out == 12'd0 && !o_word.saturated)
        else $error("speed and raw code both set");

    // a clipped code sits on an end of the code range
    a_sat_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.saturated |->
            o_word.raw_out == 12'd0 || o_word.raw_out == SatHigh)
        else $error("saturated code not at range end");

    // inverse speed stays within plus or minus one
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_word.speed_out <= pssd_pkg::ONE_Q &&
                    o_word.speed_out >= pssd_pkg::NEG_ONE_Q)
        else $error("speed out of range");

endmodule

bind pwm_speed_scaler_deadband_top pssd_checker #(.CODE_BITS(CODE_BITS)) u_pssd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_word  (o_word)
);

// ----- tb/pwm_speed_scaler_deadband_top_test.sv -----
// ----------------------------------------------------------------------------
// pwm_speed_scaler_deadband_top_test
// Self-checking bench for the PWM speed scaler with programmable deadband.
// ----------------------------------------------------------------------------
// Programs the five pulse bounds and the deadband mode, then streams forward
// (speed to pulse code) and inverse (pulse code to speed) words through the
// block. A local scaling model predicts every result, and results are matched
// in order, field by field. Random gaps on both sides, a long output hold-off
// and a stretch with no gaps exercise the handshakes.
// ----------------------------------------------------------------------------
module pwm_speed_scaler_deadband_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DISABLED_CODE = 0;
    localparam int     CODE_BITS     = 12;
    localparam longint CODE_TOP      = (longint'(1) << CODE_BITS) - 1;
    localparam longint Q_ONE         = pssd_pkg::ONE_Q;
    localparam int     RUN_LIMIT     = 200000;
    localparam int     PRINT_CAP     = 40;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    pssd_pkg::t_in_word  i_word;
    logic                o_valid;
    logic                i_stall;
    pssd_pkg::t_out_word o_word;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    pssd_pkg::t_cfg_idx  i_cfg_index;
    logic [11:0]         i_cfg_data;

    // shadow of the programmed bounds
    pssd_pkg::t_cfg      bounds;
    pssd_pkg::t_out_word pending_results[$];

    bit idle_on      = 1'b1;
    int hold_request = 0;
    int hold_left    = 0;
    int cycle_count  = 0;
    int error_count  = 0;
    int n_forward    = 0;
    int n_inverse    = 0;
    int n_clipped    = 0;
    int n_reg_writes = 0;
    int stalls_seen  = 0;

    pwm_speed_scaler_deadband_top #(
        .DISABLED_CODE(DISABLED_CODE),
        .CODE_BITS    (CODE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word     (o_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic pssd_pkg::t_out_word expected_conversion(pssd_pkg::t_in_word w);
        longint lo_pos, hi_neg, pos_span, neg_span, spd, raw, num, code, sp;
        pssd_pkg::t_out_word r;
        r = '0;
        lo_pos = bounds.skip_deadband ? longint'(bounds.deadband_high)
                                      : longint'(bounds.center_pulse) + 1;
        hi_neg = bounds.skip_deadband ? longint'(bounds.deadband_low)
                                      : longint'(bounds.center_pulse) - 1;
        pos_span = longint'(bounds.max_pulse) - lo_pos;
        neg_span = hi_neg - longint'(bounds.min_pulse);
        if (w.command == pssd_pkg::CMD_FORWARD) begin
            spd = longint'($signed(w.speed_in));
            if (spd > Q_ONE) spd = Q_ONE;
            else if (spd < -Q_ONE) spd = -Q_ONE;
            if (spd == 0) begin
                code = longint'(bounds.center_pulse);
            end else begin
                // scale on the chosen side, round half up, floor toward -inf
                num = (spd > 0) ? spd * pos_span + lo_pos * Q_ONE
                                : spd * neg_span + hi_neg * Q_ONE;
                num = num + Q_ONE / 2;
                code = (num >= 0) ? num / Q_ONE : -((-num + Q_ONE - 1) / Q_ONE);
            end
            if (code < 0) begin
                code = 0;
                r.saturated = 1'b1;
            end else if (code > CODE_TOP) begin
                code = CODE_TOP;
                r.saturated = 1'b1;
            end
            r.raw_out = code[11:0];
        end else begin
            raw = longint'(w.raw_in);
            if (raw == DISABLED_CODE) sp = 0;
            else if (raw > longint'(bounds.max_pulse)) sp = Q_ONE;
            else if (raw < longint'(bounds.min_pulse)) sp = -Q_ONE;
            else if (raw > lo_pos) sp = (pos_span != 0) ? (raw - lo_pos) * Q_ONE / pos_span : 0;
            else if (raw < hi_neg) sp = (neg_span != 0) ? (raw - hi_neg) * Q_ONE / neg_span : 0;
            else sp = 0;
            r.speed_out = sp[15:0];
        end
        return r;
    endfunction

    function automatic pssd_pkg::t_cfg make_bounds(int mx, int dh, int ct, int dl, int mn, bit sk);
        pssd_pkg::t_cfg c;
        c.max_pulse     = mx[11:0];
        c.deadband_high = dh[11:0];
        c.center_pulse  = ct[11:0];
        c.deadband_low  = dl[11:0];
        c.min_pulse     = mn[11:0];
        c.skip_deadband = sk;
        return c;
    endfunction

    function automatic pssd_pkg::t_cfg random_bounds(bit ordered);
        logic [11:0] v[5];
        foreach (v[k]) v[k] = 12'($urandom);
        if (ordered) v.sort();
        return make_bounds(int'(v[4]), int'(v[3]), int'(v[2]), int'(v[1]), int'(v[0]),
                           1'($urandom_range(1)));
    endfunction

    function automatic pssd_pkg::t_in_word fwd_word(int s);
        pssd_pkg::t_in_word w;
        w = '0;
        w.command  = pssd_pkg::CMD_FORWARD;
        w.speed_in = s[15:0];
        return w;
    endfunction

    function automatic pssd_pkg::t_in_word inv_word(int r);
        pssd_pkg::t_in_word w;
        w = '0;
        w.command = pssd_pkg::CMD_INVERSE;
        w.raw_in  = r[11:0];
        return w;
    endfunction

    function automatic pssd_pkg::t_in_word random_item();
        pssd_pkg::t_in_word w;
        int s, r, lo, hi;
        int edges[5];
        edges = '{int'(bounds.max_pulse), int'(bounds.deadband_high),
                  int'(bounds.center_pulse), int'(bounds.deadband_low),
                  int'(bounds.min_pulse)};
        w.command  = 1'($urandom_range(1));
        w.speed_in = 16'($urandom);
        w.raw_in   = 12'($urandom);
        case ($urandom_range(4))
            0: s = int'($urandom_range(32768)) - 16384;
            1: s = int'($urandom_range(128)) - 64;
            2: s = ($urandom_range(1) ? 16384 : -16384) + int'($urandom_range(2)) - 1;
            3: s = 0;
            default: s = int'($signed(w.speed_in));
        endcase
        w.speed_in = s[15:0];
        case ($urandom_range(3))
            0: begin
                r = edges[$urandom_range(4)] + int'($urandom_range(4)) - 2;
                if (r < 0) r = 0;
                if (r > 4095) r = 4095;
                w.raw_in = r[11:0];
            end
            1: begin
                lo = int'(bounds.min_pulse);
                hi = int'(bounds.max_pulse);
                if (lo <= hi) w.raw_in = 12'($urandom_range(hi, lo));
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic flag_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_result(pssd_pkg::t_out_word got);
        pssd_pkg::t_out_word want;
        if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected word %h", got));
            return;
        end
        want = pending_results.pop_front();
        if (want.saturated) n_clipped++;
        if (got.raw_out !== want.raw_out)
            flag_mismatch($sformatf("raw_out %0d, want %0d", got.raw_out, want.raw_out));
        if (got.speed_out !== want.speed_out)
            flag_mismatch($sformatf("speed_out %0d, want %0d", got.speed_out, want.speed_out));
        if (got.saturated !== want.saturated)
            flag_mismatch($sformatf("saturated %b, want %b", got.saturated, want.saturated));
    endtask

    // output side: take words, random stalls, long hold-off on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) check_result(o_word);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_request > 0) begin
                hold_left = hold_request - 1;
                hold_request = 0;
                i_stall <= 1'b1;
            end else begin
                i_stall <= idle_on && ($urandom_range(99) < 8);
            end
        end
    end

    task automatic send_word(pssd_pkg::t_in_word w);
        if (idle_on && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do begin
            @(posedge i_clk);
            if (o_stall === 1'b1) stalls_seen++;
        end while (o_stall !== 1'b0);
        pending_results.push_back(expected_conversion(w));
        if (w.command == pssd_pkg::CMD_FORWARD) n_forward++;
        else n_inverse++;
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(pssd_pkg::t_cfg_idx idx, logic [11:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            pssd_pkg::CFG_MAX_PULSE:     bounds.max_pulse     = data;
            pssd_pkg::CFG_DEADBAND_HIGH: bounds.deadband_high = data;
            pssd_pkg::CFG_CENTER_PULSE:  bounds.center_pulse  = data;
            pssd_pkg::CFG_DEADBAND_LOW:  bounds.deadband_low  = data;
            pssd_pkg::CFG_MIN_PULSE:     bounds.min_pulse     = data;
            pssd_pkg::CFG_SKIP_DEADBAND: bounds.skip_deadband = data[0];
            default: ;
        endcase
        n_reg_writes++;
    endtask

    task automatic apply_config(pssd_pkg::t_cfg c);
        drain();
        write_reg(pssd_pkg::CFG_MAX_PULSE, c.max_pulse);
        write_reg(pssd_pkg::CFG_DEADBAND_HIGH, c.deadband_high);
        write_reg(pssd_pkg::CFG_CENTER_PULSE, c.center_pulse);
        write_reg(pssd_pkg::CFG_DEADBAND_LOW, c.deadband_low);
        write_reg(pssd_pkg::CFG_MIN_PULSE, c.min_pulse);
        write_reg(pssd_pkg::CFG_SKIP_DEADBAND, {11'd0, c.skip_deadband});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_word(fwd_word(0));
        send_word(fwd_word(16384));
        send_word(fwd_word(-16384));
        send_word(inv_word(0));
        send_word(inv_word(4095));
    endtask

    task automatic test_directed();
        int speeds[10] = '{0, 16384, -16384, 32767, -32768, 1, -1, 8192, -8192, 16385};
        int raws[11]   = '{0, 4095, 1, 2000, 1000, 1500, 1520, 1480, 1521, 1479, 1750};
        apply_config(make_bounds(2000, 1520, 1500, 1480, 1000, 1'b1));
        foreach (speeds[k]) send_word(fwd_word(speeds[k]));
        foreach (raws[k]) send_word(inv_word(raws[k]));
        // deadband eliminated: sides start next to center
        apply_config(make_bounds(2000, 1520, 1500, 1480, 1000, 1'b0));
        send_word(fwd_word(1));
        send_word(fwd_word(-1));
        send_word(inv_word(1501));
        send_word(inv_word(1499));
    endtask

    // inconsistent bounds, zero scales, code range corners
    task automatic test_config_extremes();
        int speeds[7] = '{0, 16384, -16384, 1, -1, 8191, -8191};
        int raws[7]   = '{0, 1, 2047, 2048, 2049, 4094, 4095};
        pssd_pkg::t_cfg corners[6];
        corners[0] = make_bounds(0, 0, 0, 0, 0, 1'b0);
        corners[1] = make_bounds(4095, 4095, 4095, 4095, 4095, 1'b1);
        corners[2] = make_bounds(4095, 4095, 4095, 0, 0, 1'b0);
        corners[3] = make_bounds(0, 100, 2048, 3000, 4095, 1'b0);
        corners[4] = make_bounds(4095, 2100, 2048, 2000, 0, 1'b1);
        corners[5] = make_bounds(3000, 3000, 2048, 1000, 1000, 1'b1);
        foreach (corners[c]) begin
            apply_config(corners[c]);
            foreach (speeds[k]) send_word(fwd_word(speeds[k]));
            foreach (raws[k]) send_word(inv_word(raws[k]));
        end
    endtask

    task automatic test_random_configs();
        repeat (6) begin
            apply_config(random_bounds($urandom_range(3) != 0));
            repeat (200) send_word(random_item());
        end
    endtask

    task automatic test_no_idling();
        apply_config(random_bounds(1'b1));
        idle_on = 1'b0;
        repeat (300) send_word(random_item());
        idle_on = 1'b1;
    endtask

    // hold the output long enough that the pipeline fills and stalls its input
    task automatic test_backpressure();
        apply_config(random_bounds(1'b1));
        hold_request = 120;
        repeat (60) send_word(random_item());
    endtask

    initial begin
        bounds      = '0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_word      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= pssd_pkg::CFG_MAX_PULSE;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed();
        test_config_extremes();
        test_random_configs();
        test_no_idling();
        test_backpressure();
        drain();
        repeat (10) @(posedge i_clk);

        $display("checked %0d forward and %0d inverse words across %0d register writes",
                 n_forward, n_inverse, n_reg_writes);
        $display("%0d clipped codes expected, input stalled on %0d cycles",
                 n_clipped, stalls_seen);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
